// ===== design/rate_and_magnitude_limiter_top_macros.svh =====
// Assertion macros for the rate and magnitude limiter.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RATE_AND_MAGNITUDE_LIMITER_TOP_MACROS_SVH
`define RATE_AND_MAGNITUDE_LIMITER_TOP_MACROS_SVH

// A property checked at every clock edge outside reset.
`define RML_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define RML_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/rml_pkg.sv =====
// Shared types, constants and helpers for the rate and magnitude limiter.
// Used by rml_front, rml_back and rate_and_magnitude_limiter_top.
package rml_pkg;

  localparam int VALUE_WIDTH        = 32;
  localparam int FRACTION_BITS      = 16;
  localparam int STEP_WIDTH         = VALUE_WIDTH - 1;
  localparam int GAIN_WIDTH         = 16;
  localparam int GAIN_FRACTION_BITS = 16;
  localparam int OFFSET_WIDTH       = 8;
  localparam int NOISE_PERCENT      = 100;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_INDEX_WIDTH    = 3;

  localparam int RATE_PROD_W  = 2 * VALUE_WIDTH;
  localparam int NOISE_PROD1_W = VALUE_WIDTH + GAIN_WIDTH + 1;
  localparam int NOISE_PROD2_W = NOISE_PROD1_W + OFFSET_WIDTH;
  localparam int TERM_W        = NOISE_PROD2_W - GAIN_FRACTION_BITS;
  localparam int SAT_IN_W      = (RATE_PROD_W > TERM_W + 1) ? RATE_PROD_W : TERM_W + 1;

  // The divide by one hundred retires DIV_DIGIT quotient bits per cycle.
  localparam int DIV_DIGIT = 4;
  localparam int DIV_W     = ((TERM_W + DIV_DIGIT - 1) / DIV_DIGIT) * DIV_DIGIT;
  localparam int DIV_STEPS = DIV_W / DIV_DIGIT;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = $clog2(NOISE_PERCENT);

  typedef logic signed [VALUE_WIDTH-1:0]  value_t;
  typedef logic signed [OFFSET_WIDTH-1:0] offset_t;
  typedef logic signed [SAT_IN_W-1:0]     wide_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_LOWER_LIMIT = 3'd0,
    CFG_UPPER_LIMIT = 3'd1,
    CFG_FALL_RATE   = 3'd2,
    CFG_RISE_RATE   = 3'd3,
    CFG_STEP_TIME   = 3'd4,
    CFG_BIAS_OFFSET = 3'd5,
    CFG_NOISE_GAIN  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    value_t                  lower_limit;
    value_t                  upper_limit;
    value_t                  fall_rate;
    value_t                  rise_rate;
    logic [STEP_WIDTH-1:0]   step_time;
    value_t                  bias_offset;
    logic [GAIN_WIDTH-1:0]   noise_gain;
  } cfg_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam cfg_t CFG_RESET = '{
    lower_limit: VALUE_MIN,
    upper_limit: VALUE_MAX,
    fall_rate:   VALUE_MIN,
    rise_rate:   VALUE_MAX,
    step_time:   STEP_WIDTH'(1) << FRACTION_BITS,
    bias_offset: '0,
    noise_gain:  '0
  };

  typedef struct packed {
    value_t  command_value;
    offset_t noise_offset;
    logic    restart;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } front_status_t;

  typedef struct packed {
    logic busy;
    logic finishing;
  } back_status_t;

  // Saturates a wide signed value to the value range.
  function automatic value_t sat_value(input wide_t v);
    logic [SAT_IN_W-VALUE_WIDTH:0] top;
    top = v[SAT_IN_W-1:VALUE_WIDTH-1];
    if ((&top) || !(|top)) begin
      return v[VALUE_WIDTH-1:0];
    end else if (v[SAT_IN_W-1]) begin
      return VALUE_MIN;
    end else begin
      return VALUE_MAX;
    end
  endfunction

endpackage

// ===== design/rml_front.sv =====
// Input side of the limiter: takes items and holds them in a short queue.
// Depends on rml_pkg for the item and status types.
module rml_front #(
  parameter int unsigned DEPTH = rml_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rml_pkg::item_t        item_i,
  output logic                  item_valid_o,
  output rml_pkg::item_t        item_o,
  input  logic                  pop_i,
  output rml_pkg::front_status_t status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rml_pkg::item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic push;
  logic pop;

  assign in_ready_o   = (count_q != CNT_W'(DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && (count_q != '0);
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = !in_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/rml_back.sv =====
// Processing side of the limiter: rate window, clamp, bias and noise scaling,
// ending in the output register. Depends on rml_pkg.
module rml_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rml_pkg::cfg_t         cfg_i,
  input  logic                  item_valid_i,
  input  rml_pkg::item_t        item_i,
  output logic                  item_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rml_pkg::value_t       limited_value_o,
  output rml_pkg::back_status_t status_o
);

  localparam int VW   = rml_pkg::VALUE_WIDTH;
  localparam int SW   = rml_pkg::SAT_IN_W;
  localparam int RPW  = rml_pkg::RATE_PROD_W;
  localparam int NP1  = rml_pkg::NOISE_PROD1_W;
  localparam int NP2  = rml_pkg::NOISE_PROD2_W;
  localparam int TW   = rml_pkg::TERM_W;
  localparam int DW   = rml_pkg::DIV_W;
  localparam int RW   = rml_pkg::REM_W;
  localparam int CW   = rml_pkg::DIV_CNT_W;
  localparam logic [RW:0] DIV_CONST = (RW + 1)'(rml_pkg::NOISE_PERCENT);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_RATE  = 10'b00_0000_0010,
    ST_WIN   = 10'b00_0000_0100,
    ST_CLAMP = 10'b00_0000_1000,
    ST_BIAS  = 10'b00_0001_0000,
    ST_MULG  = 10'b00_0010_0000,
    ST_MULO  = 10'b00_0100_0000,
    ST_PREP  = 10'b00_1000_0000,
    ST_DIV   = 10'b01_0000_0000,
    ST_FIX   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  rml_pkg::value_t lower_s, upper_s, fall_s, rise_s, bias_s;

  rml_pkg::value_t  cmd_q;
  rml_pkg::offset_t ofs_q;
  rml_pkg::value_t  prev_q;
  rml_pkg::value_t  val_q;
  logic signed [RPW-1:0] pdn_q, pup_q;
  rml_pkg::value_t  dn_q, up_q;
  logic signed [NP1-1:0] p1_q;
  logic signed [NP2-1:0] p2_q;
  logic             neg_q;
  logic [DW-1:0]    quo_q;
  logic [RW-1:0]    rem_q;
  logic [CW-1:0]    cnt_q;
  logic             out_valid_q;
  rml_pkg::value_t  out_data_q;

  rml_pkg::value_t  win_floor, win_ceil, clamped, biased, final_res;
  logic signed [NP2-1:0] noise_shifted;
  logic signed [TW-1:0]  noise_s;
  logic [TW-1:0]    noise_mag;
  logic [RW:0]      div_rem;
  logic [DW-1:0]    div_quo;
  logic signed [TW:0] quo_ext, term;
  logic             slot_free;

  assign lower_s = cfg_i.lower_limit;
  assign upper_s = cfg_i.upper_limit;
  assign fall_s  = cfg_i.fall_rate;
  assign rise_s  = cfg_i.rise_rate;
  assign bias_s  = cfg_i.bias_offset;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  // Window around the previous value, narrowed by the magnitude limits.
  // When the floor ends up above the ceiling, the floor wins.
  always_comb begin
    win_floor = rml_pkg::sat_value(SW'(prev_q) + SW'(dn_q));
    win_ceil  = rml_pkg::sat_value(SW'(prev_q) + SW'(up_q));
    if (win_floor < lower_s) begin
      win_floor = lower_s;
    end
    if (win_ceil > upper_s) begin
      win_ceil = upper_s;
    end
    clamped = cmd_q;
    if (clamped > win_ceil) begin
      clamped = win_ceil;
    end
    if (clamped < win_floor) begin
      clamped = win_floor;
    end
  end

  // Bias, then the magnitude clamp in which the upper limit has the last word.
  always_comb begin
    biased = rml_pkg::sat_value(SW'(val_q) + SW'(bias_s));
    if (biased < lower_s) begin
      biased = lower_s;
    end
    if (biased > upper_s) begin
      biased = upper_s;
    end
  end

  assign noise_shifted = p2_q >>> rml_pkg::GAIN_FRACTION_BITS;
  assign noise_s       = noise_shifted[TW-1:0];
  assign noise_mag     = noise_s[TW-1] ? TW'(-noise_s) : TW'(noise_s);

  // Restoring division of the magnitude by one hundred, a few bits per cycle.
  // The quotient bits shift into the bottom of the same register.
  always_comb begin
    div_rem = {1'b0, rem_q};
    div_quo = quo_q;
    for (int i = 0; i < rml_pkg::DIV_DIGIT; i++) begin
      div_rem = {div_rem[RW-1:0], div_quo[DW-1]};
      div_quo = {div_quo[DW-2:0], 1'b0};
      if (div_rem >= DIV_CONST) begin
        div_rem    = div_rem - DIV_CONST;
        div_quo[0] = 1'b1;
      end
    end
  end

  // Floor rounding: a negative quotient with a remainder moves down by one.
  assign quo_ext = $signed({1'b0, quo_q[TW-1:0]});
  assign term    = neg_q ? (-quo_ext - $signed({{TW{1'b0}}, (rem_q != '0)}))
                         : quo_ext;
  assign final_res = rml_pkg::sat_value(SW'(val_q) + SW'(term));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (item_valid_i) begin
                  state_d = ST_RATE;
                end
      ST_RATE:  state_d = ST_WIN;
      ST_WIN:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_BIAS;
      ST_BIAS:  state_d = ST_MULG;
      ST_MULG:  state_d = ST_MULO;
      ST_MULO:  state_d = ST_PREP;
      ST_PREP:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) begin
                  state_d = ST_FIX;
                end
      ST_FIX:   if (slot_free) begin
                  state_d = ST_IDLE;
                end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (item_pop_o && item_i.restart) begin
        prev_q <= '0;
      end else if (state_q == ST_CLAMP) begin
        prev_q <= clamped;
      end
      if ((state_q == ST_FIX) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q <= item_i.command_value;
        ofs_q <= item_i.noise_offset;
      end
      ST_RATE: begin
        pdn_q <= $signed({1'b0, cfg_i.step_time}) * fall_s;
        pup_q <= $signed({1'b0, cfg_i.step_time}) * rise_s;
      end
      ST_WIN: begin
        dn_q <= rml_pkg::sat_value(SW'(pdn_q >>> rml_pkg::FRACTION_BITS));
        up_q <= rml_pkg::sat_value(SW'(pup_q >>> rml_pkg::FRACTION_BITS));
      end
      ST_CLAMP: val_q <= clamped;
      ST_BIAS:  val_q <= biased;
      ST_MULG:  p1_q <= NP1'(val_q) * $signed({{VW{1'b0}}, cfg_i.noise_gain});
      ST_MULO:  p2_q <= NP2'(p1_q) * NP2'(ofs_q);
      ST_PREP: begin
        neg_q <= noise_s[TW-1];
        quo_q <= DW'(noise_mag);
        rem_q <= '0;
        cnt_q <= CW'(rml_pkg::DIV_STEPS - 1);
      end
      ST_DIV: begin
        quo_q <= div_quo;
        rem_q <= div_rem[RW-1:0];
        cnt_q <= cnt_q - 1'b1;
      end
      ST_FIX: if (slot_free) begin
        out_data_q <= final_res;
      end
      default: ;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign limited_value_o    = out_data_q;
  assign status_o.busy      = (state_q != ST_IDLE);
  assign status_o.finishing = (state_q == ST_FIX) && slot_free;

endmodule

// ===== design/rate_and_magnitude_limiter_top.sv =====
// Top level of the rate and magnitude limiter: configuration registers,
// input queue (rml_front) and processing sequencer (rml_back). Uses rml_pkg.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_ready_o   command_value_i, noise_offset_i, restart_i
//   output    out        out_valid_o / out_ready_i limited_value_o
//   config    in         cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// The sequencer takes one item at a time: it pops the item in ST_IDLE, then steps
// through ST_RATE, ST_WIN, ST_CLAMP, ST_BIAS, ST_MULG, ST_MULO, ST_PREP, a divide by
// one hundred in ST_DIV that yields four quotient bits per cycle, and ST_FIX.
// The input queue accepts while not full, also while the sequencer works or a result waits.
// Reset clears the queue, the previous value and the output valid flag, and
// loads the register defaults. A stalled output holds the sequencer in its last step.
`include "rate_and_magnitude_limiter_top_macros.svh"

module rate_and_magnitude_limiter_top #(
  parameter int unsigned QUEUE_DEPTH = rml_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rml_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [rml_pkg::VALUE_WIDTH-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  rml_pkg::value_t                       command_value_i,
  input  rml_pkg::offset_t                      noise_offset_i,
  input  logic                                  restart_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output rml_pkg::value_t                       limited_value_o
);

  rml_pkg::cfg_t          cfg_q;
  rml_pkg::item_t         item_in;
  rml_pkg::item_t         item_q;
  logic                   item_valid;
  logic                   item_pop;
  rml_pkg::front_status_t front_st;
  rml_pkg::back_status_t  back_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rml_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (rml_pkg::cfg_idx_e'(cfg_index_i))
        rml_pkg::CFG_LOWER_LIMIT: cfg_q.lower_limit <= cfg_wdata_i;
        rml_pkg::CFG_UPPER_LIMIT: cfg_q.upper_limit <= cfg_wdata_i;
        rml_pkg::CFG_FALL_RATE:   cfg_q.fall_rate   <= cfg_wdata_i;
        rml_pkg::CFG_RISE_RATE:   cfg_q.rise_rate   <= cfg_wdata_i;
        rml_pkg::CFG_STEP_TIME:
          cfg_q.step_time <= cfg_wdata_i[rml_pkg::STEP_WIDTH-1:0];
        rml_pkg::CFG_BIAS_OFFSET: cfg_q.bias_offset <= cfg_wdata_i;
        rml_pkg::CFG_NOISE_GAIN:
          cfg_q.noise_gain <= cfg_wdata_i[rml_pkg::GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign item_in.command_value = command_value_i;
  assign item_in.noise_offset  = noise_offset_i;
  assign item_in.restart       = restart_i;

  rml_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_i      (item_in),
    .item_valid_o(item_valid),
    .item_o      (item_q),
    .pop_i       (item_pop),
    .status_o    (front_st)
  );

  rml_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (item_valid),
    .item_i         (item_q),
    .item_pop_o     (item_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .limited_value_o(limited_value_o),
    .status_o       (back_st)
  );

  `RML_ASSERT(a_pop_has_item, item_pop |-> !front_st.empty, "pop from an empty queue")
  `RML_ASSERT_NEXT(a_push_fills, in_valid_i && in_ready_o && !item_pop, !front_st.empty, "queue lost a transaction")
  `RML_ASSERT_NEXT(a_pop_starts_work, item_pop, back_st.busy, "sequencer ignored a popped item")
  `RML_ASSERT(a_result_from_back, $rose(out_valid_o) |-> $past(back_st.finishing), "result without a finished item")

endmodule
